[rtl/gsf_pkg.sv]
package gsf_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned KindWidth   = 2;
   localparam int unsigned ErrorWidth  = 2;
   localparam int unsigned RemainWidth = 17;

   localparam logic [ByteWidth-1:0] MaxLenReset = 8'd82;

   // frame kind tags
   localparam logic [KindWidth-1:0] KIND_DROPPED = 2'd0;
   localparam logic [KindWidth-1:0] KIND_ASCII   = 2'd1;
   localparam logic [KindWidth-1:0] KIND_BINARY  = 2'd2;

   // error codes
   localparam logic [ErrorWidth-1:0] ERR_NONE     = 2'd0;
   localparam logic [ErrorWidth-1:0] ERR_CHECKSUM = 2'd1;
   localparam logic [ErrorWidth-1:0] ERR_TOO_LONG = 2'd2;

   // special bytes
   localparam logic [ByteWidth-1:0] CHAR_DOLLAR   = 8'h24;
   localparam logic [ByteWidth-1:0] CHAR_STAR     = 8'h2A;
   localparam logic [ByteWidth-1:0] CHAR_LF       = 8'h0A;
   localparam logic [ByteWidth-1:0] SYNC_FIRST    = 8'hA0;
   localparam logic [ByteWidth-1:0] SYNC_SECOND   = 8'hA1;
   localparam logic [RemainWidth-1:0] BIN_EXTRA   = 17'd3;

   typedef struct packed {
      logic [ByteWidth-1:0]  out_byte;
      logic [KindWidth-1:0]  frame_kind;
      logic                  frame_start;
      logic                  frame_end;
      logic                  checksum_ok;
      logic [ErrorWidth-1:0] error_code;
   } result_type;

   // value of an uppercase hex digit, bit 4 set when not a digit
   function automatic logic [4:0] hex_value(input logic [ByteWidth-1:0] b);
      logic [4:0] v;
      v = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = 5'(b - 8'h30);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = 5'(b - 8'h37);
      end
      return v;
   endfunction

endpackage

[rtl/gnss_sentence_framer.sv]
// GNSS byte-stream framer: every accepted request byte yields exactly one
// tagged response carrying the byte, its frame kind (dropped, NMEA sentence
// or A0 A1 binary frame), start/end flags, the checksum verdict on the line
// feed that closes a sentence and an error code (malformed or missing checksum,
// sentence too long). A byte is taken every cycle while req_stall is low; the
// framing state is updated as it is accepted and its response is registered
// in the output register, or in the one-entry skid register behind it, so the
// request side keeps flowing while one response waits and req_stall rises
// only when both are full. csr_data sets the longest sentence (reset 82);
// write it only while no request is outstanding.
module gnss_sentence_framer (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [gsf_pkg::ByteWidth-1:0]       req_rx_byte,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gsf_pkg::ByteWidth-1:0]       rsp_out_byte,
   output logic [gsf_pkg::KindWidth-1:0]       rsp_frame_kind,
   output logic                                rsp_frame_start,
   output logic                                rsp_frame_end,
   output logic                                rsp_checksum_ok,
   output logic [gsf_pkg::ErrorWidth-1:0]      rsp_error_code,
   // configuration write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gsf_pkg::ByteWidth-1:0]       csr_data
);

   logic                              accept;
   logic                              out_free;
   gsf_pkg::result_type               result;
   gsf_pkg::result_type               out_ff, skid_ff;
   logic                              out_valid_ff, skid_valid_ff;
   logic [gsf_pkg::ByteWidth-1:0]     max_len_ff;

   // configuration register is always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= gsf_pkg::MaxLenReset;
      end else if (csr_valid) begin
         max_len_ff <= csr_data;
      end
   end

   // stall only once the skid register is holding a response
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign out_free  = ~out_valid_ff | ~rsp_stall;

   gsf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .max_len (max_len_ff),
      .result  (result)
   );

   // output register with skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_ff.out_byte;
   assign rsp_frame_kind  = out_ff.frame_kind;
   assign rsp_frame_start = out_ff.frame_start;
   assign rsp_frame_end   = out_ff.frame_end;
   assign rsp_checksum_ok = out_ff.checksum_ok;
   assign rsp_error_code  = out_ff.error_code;

endmodule

[rtl/gsf_parser.sv]
module gsf_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [gsf_pkg::ByteWidth-1:0]  rx_byte,
   input  logic [gsf_pkg::ByteWidth-1:0]  max_len,
   output gsf_pkg::result_type            result
);

   typedef enum logic [3:0] {
      PH_HUNT     = 4'd0,
      PH_SYNC     = 4'd1,
      PH_LEN_HI   = 4'd2,
      PH_LEN_LO   = 4'd3,
      PH_BIN_BODY = 4'd4,
      PH_TEXT     = 4'd5,
      PH_HEX_HI   = 4'd6,
      PH_HEX_LO   = 4'd7,
      PH_TAIL     = 4'd8
   } phase_type;

   phase_type                          phase_ff, phase_in, eff_phase;
   logic [gsf_pkg::ByteWidth-1:0]      xor_sum_ff, xor_sum_in;
   logic [gsf_pkg::ByteWidth-1:0]      hex_rx_ff, hex_rx_in;
   logic                               hex_fault_ff, hex_fault_in;
   logic [gsf_pkg::ByteWidth-1:0]      count_ff, count_in;
   logic [gsf_pkg::ByteWidth-1:0]      len_hi_ff, len_hi_in;
   logic [gsf_pkg::RemainWidth-1:0]    remain_ff, remain_in;
   logic [4:0]                         digit_raw;
   logic [3:0]                         digit;

   assign digit_raw = gsf_pkg::hex_value(rx_byte);
   assign digit     = digit_raw[4] ? 4'd0 : digit_raw[3:0];

   always_comb begin
      phase_in     = phase_ff;
      xor_sum_in   = xor_sum_ff;
      hex_rx_in    = hex_rx_ff;
      hex_fault_in = hex_fault_ff;
      count_in     = count_ff;
      len_hi_in    = len_hi_ff;
      remain_in    = remain_ff;
      result.out_byte    = rx_byte;
      result.frame_kind  = gsf_pkg::KIND_DROPPED;
      result.frame_start = 1'b0;
      result.frame_end   = 1'b0;
      result.checksum_ok = 1'b0;
      result.error_code  = gsf_pkg::ERR_NONE;

      // a failed sync falls back to hunting for this byte
      eff_phase = (phase_ff == PH_SYNC) ? PH_HUNT : phase_ff;

      if (phase_ff == PH_SYNC && rx_byte == gsf_pkg::SYNC_SECOND) begin
         result.frame_kind  = gsf_pkg::KIND_BINARY;
         result.frame_start = 1'b1;
         phase_in           = PH_LEN_HI;
      end else begin
         phase_in = eff_phase;
         unique case (eff_phase)
            PH_HUNT: begin
               priority if (rx_byte == gsf_pkg::CHAR_DOLLAR) begin
                  result.frame_kind  = gsf_pkg::KIND_ASCII;
                  result.frame_start = 1'b1;
                  xor_sum_in         = '0;
                  hex_rx_in          = '0;
                  hex_fault_in       = 1'b0;
                  count_in           = 8'd1;
                  if (max_len == '0) begin
                     result.frame_end  = 1'b1;
                     result.error_code = gsf_pkg::ERR_TOO_LONG;
                  end else begin
                     phase_in = PH_TEXT;
                  end
               end else if (rx_byte == gsf_pkg::SYNC_FIRST) begin
                  phase_in = PH_SYNC;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_LEN_HI: begin
               result.frame_kind = gsf_pkg::KIND_BINARY;
               len_hi_in         = rx_byte;
               phase_in          = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               result.frame_kind = gsf_pkg::KIND_BINARY;
               remain_in = {1'b0, len_hi_ff, rx_byte} + gsf_pkg::BIN_EXTRA;
               phase_in  = PH_BIN_BODY;
            end
            PH_BIN_BODY: begin
               result.frame_kind = gsf_pkg::KIND_BINARY;
               remain_in         = remain_ff - 17'd1;
               if (remain_in == '0) begin
                  result.frame_end = 1'b1;
                  phase_in         = PH_HUNT;
               end
            end
            PH_TEXT, PH_HEX_HI, PH_HEX_LO, PH_TAIL: begin
               result.frame_kind = gsf_pkg::KIND_ASCII;
               priority if (count_ff >= max_len) begin
                  result.frame_end  = 1'b1;
                  result.error_code = gsf_pkg::ERR_TOO_LONG;
                  phase_in          = PH_HUNT;
               end else begin
                  count_in = count_ff + 8'd1;
                  priority if (rx_byte == gsf_pkg::CHAR_LF) begin
                     result.frame_end = 1'b1;
                     if (eff_phase != PH_TAIL || hex_fault_ff) begin
                        result.error_code = gsf_pkg::ERR_CHECKSUM;
                     end else begin
                        result.checksum_ok = (xor_sum_ff == hex_rx_ff);
                     end
                     phase_in = PH_HUNT;
                  end else if (eff_phase == PH_TEXT) begin
                     if (rx_byte == gsf_pkg::CHAR_STAR) begin
                        phase_in = PH_HEX_HI;
                     end else begin
                        xor_sum_in = xor_sum_ff ^ rx_byte;
                     end
                  end else if (eff_phase == PH_HEX_HI) begin
                     hex_fault_in = hex_fault_ff | digit_raw[4];
                     hex_rx_in    = {digit, 4'd0};
                     phase_in     = PH_HEX_LO;
                  end else if (eff_phase == PH_HEX_LO) begin
                     hex_fault_in = hex_fault_ff | digit_raw[4];
                     hex_rx_in    = {hex_rx_ff[7:4], digit};
                     phase_in     = PH_TAIL;
                  end else begin
                     // trailing bytes such as carriage return pass unchecked
                     phase_in = PH_TAIL;
                  end
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         xor_sum_ff   <= '0;
         hex_rx_ff    <= '0;
         hex_fault_ff <= 1'b0;
         count_ff     <= '0;
         len_hi_ff    <= '0;
         remain_ff    <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         xor_sum_ff   <= xor_sum_in;
         hex_rx_ff    <= hex_rx_in;
         hex_fault_ff <= hex_fault_in;
         count_ff     <= count_in;
         len_hi_ff    <= len_hi_in;
         remain_ff    <= remain_in;
      end
   end

endmodule

[tb/sv/gnss_sentence_framer_tb.sv]
`timescale 1ns / 100ps

module gnss_sentence_framer_tb;
   import gsf_pkg::*;

   // generous ceiling for a run of under a thousand bytes
   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int unsigned MAX_REPORTS = 40;
   localparam logic [ByteWidth-1:0] CHAR_CR = 8'h0D;

   // framing phases tracked by the predictor
   typedef enum logic [3:0] {
      HUNTING,
      SYNC_SEEN,
      LEN_HIGH,
      LEN_LOW,
      BIN_BODY,
      SENT_TEXT,
      SENT_HEX_HI,
      SENT_HEX_LO,
      SENT_TAIL
   } phase_type;

   // ways of damaging a sentence on purpose
   typedef enum int {
      FLAW_NONE,
      FLAW_SUM,
      FLAW_DIGIT,
      FLAW_NO_STAR,
      FLAW_ONE_DIGIT,
      FLAW_NO_DIGITS
   } sentence_flaw_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [ByteWidth-1:0]   req_rx_byte;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [ByteWidth-1:0]   rsp_out_byte;
   logic [KindWidth-1:0]   rsp_frame_kind;
   logic                   rsp_frame_start;
   logic                   rsp_frame_end;
   logic                   rsp_checksum_ok;
   logic [ErrorWidth-1:0]  rsp_error_code;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [ByteWidth-1:0]   csr_data;

   // predictor copy of the framing state and the length register
   phase_type              phase;
   logic [ByteWidth-1:0]   max_len;
   logic [ByteWidth-1:0]   run_xor;
   logic [ByteWidth-1:0]   sum_given;
   logic                   digit_fault;
   logic [ByteWidth-1:0]   sent_len;
   logic [ByteWidth-1:0]   len_high;
   logic [RemainWidth-1:0] bin_left;

   result_type             expected_tags[$];
   logic [ByteWidth-1:0]   sentence_body[$];
   int unsigned            bytes_sent;
   int unsigned            error_count;
   int unsigned            cycle_count;
   bit                     steady;

   gnss_sentence_framer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_frame_start (rsp_frame_start),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_error_code  (rsp_error_code),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   // uppercase hex digit value, bit 4 flags a non-digit
   function automatic logic [4:0] digit_value(input logic [ByteWidth-1:0] b);
      if (b >= "0" && b <= "9") begin
         return {1'b0, b[3:0]};
      end
      if (b >= "A" && b <= "F") begin
         return {1'b0, b[3:0] + 4'd9};
      end
      return 5'h10;
   endfunction

   // tag one accepted byte and advance the framing state
   function automatic result_type tag_byte(input logic [ByteWidth-1:0] b);
      result_type r;
      logic [4:0] d;
      logic       taken;
      r             = '0;
      r.out_byte    = b;
      r.frame_kind  = KIND_DROPPED;
      r.error_code  = ERR_NONE;
      taken         = 1'b0;
      // byte after a lone A0: only A1 completes the sync
      if (phase == SYNC_SEEN) begin
         if (b == SYNC_SECOND) begin
            r.frame_kind  = KIND_BINARY;
            r.frame_start = 1'b1;
            phase         = LEN_HIGH;
            taken         = 1'b1;
         end else begin
            phase = HUNTING;
         end
      end
      if (!taken) begin
         case (phase)
            HUNTING: begin
               if (b == CHAR_DOLLAR) begin
                  r.frame_kind  = KIND_ASCII;
                  r.frame_start = 1'b1;
                  run_xor       = '0;
                  sum_given     = '0;
                  digit_fault   = 1'b0;
                  sent_len      = 8'd1;
                  // a zero limit aborts on the dollar itself
                  if (max_len == 8'd0) begin
                     r.frame_end  = 1'b1;
                     r.error_code = ERR_TOO_LONG;
                  end else begin
                     phase = SENT_TEXT;
                  end
               end else if (b == SYNC_FIRST) begin
                  phase = SYNC_SEEN;
               end
            end
            LEN_HIGH: begin
               r.frame_kind = KIND_BINARY;
               len_high     = b;
               phase        = LEN_LOW;
            end
            LEN_LOW: begin
               // high byte weighs 256
               r.frame_kind = KIND_BINARY;
               bin_left     = RemainWidth'({len_high, b}) + BIN_EXTRA;
               phase        = BIN_BODY;
            end
            BIN_BODY: begin
               r.frame_kind = KIND_BINARY;
               bin_left     = bin_left - 1'b1;
               if (bin_left == '0) begin
                  r.frame_end = 1'b1;
                  phase       = HUNTING;
               end
            end
            SENT_TEXT, SENT_HEX_HI, SENT_HEX_LO, SENT_TAIL: begin
               r.frame_kind = KIND_ASCII;
               if (sent_len >= max_len) begin
                  r.frame_end  = 1'b1;
                  r.error_code = ERR_TOO_LONG;
                  phase        = HUNTING;
               end else begin
                  sent_len = sent_len + 1'b1;
                  if (b == CHAR_LF) begin
                     r.frame_end = 1'b1;
                     if (phase != SENT_TAIL || digit_fault) begin
                        r.error_code = ERR_CHECKSUM;
                     end else begin
                        r.checksum_ok = (run_xor == sum_given);
                     end
                     phase = HUNTING;
                  end else if (phase == SENT_TEXT) begin
                     if (b == CHAR_STAR) begin
                        phase = SENT_HEX_HI;
                     end else begin
                        run_xor = run_xor ^ b;
                     end
                  end else if (phase != SENT_TAIL) begin
                     d = digit_value(b);
                     if (d[4]) begin
                        digit_fault = 1'b1;
                        d           = '0;
                     end
                     if (phase == SENT_HEX_HI) begin
                        sum_given = {d[3:0], 4'h0};
                        phase     = SENT_HEX_LO;
                     end else begin
                        sum_given[3:0] = d[3:0];
                        phase          = SENT_TAIL;
                     end
                  end
               end
            end
            default: begin
               phase = HUNTING;
            end
         endcase
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [ByteWidth-1:0] rx,
                                  input int got, input int want);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("mismatch %s on byte %02h: got %0h, expected %0h", what, rx, got, want);
      end
   endtask

   // each accepted response against the oldest predicted tag
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tags.size() == 0) begin
            report_mismatch("unexpected response", rsp_out_byte, 0, 0);
         end else begin
            want = expected_tags.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               report_mismatch("out_byte", want.out_byte, rsp_out_byte, want.out_byte);
            end
            if (rsp_frame_kind !== want.frame_kind) begin
               report_mismatch("frame_kind", want.out_byte, rsp_frame_kind, want.frame_kind);
            end
            if (rsp_frame_start !== want.frame_start) begin
               report_mismatch("frame_start", want.out_byte, rsp_frame_start,
                               want.frame_start);
            end
            if (rsp_frame_end !== want.frame_end) begin
               report_mismatch("frame_end", want.out_byte, rsp_frame_end, want.frame_end);
            end
            if (rsp_checksum_ok !== want.checksum_ok) begin
               report_mismatch("checksum_ok", want.out_byte, rsp_checksum_ok,
                               want.checksum_ok);
            end
            if (rsp_error_code !== want.error_code) begin
               report_mismatch("error_code", want.out_byte, rsp_error_code, want.error_code);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL gnss_sentence_framer");
         $finish;
      end
   end

   // response side: random stall per response, none while steady
   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         hold = steady ? 0 : $urandom_range(0, 6);
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall = 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // one request: random gap, then hold until accepted
   task automatic send_byte(input logic [ByteWidth-1:0] b);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      repeat (gap) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (req_stall);
      expected_tags.push_back(tag_byte(b));
      bytes_sent++;
   endtask

   // lower the request and let every response drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_tags.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [ByteWidth-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      max_len = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [ByteWidth-1:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
   endfunction

   // random sentence content, never star, line feed or the A0 sync byte
   function automatic logic [ByteWidth-1:0] body_char();
      logic [ByteWidth-1:0] c;
      do c = 8'($urandom); while (c == CHAR_STAR || c == CHAR_LF || c == SYNC_FIRST);
      return c;
   endfunction

   task automatic fill_body(input int len);
      sentence_body.delete();
      repeat (len) sentence_body.push_back(body_char());
   endtask

   // body length, a quarter of the time near the length limit when it is at least 8
   function automatic int sentence_body_len();
      int len;
      if (max_len >= 8'd8 && $urandom_range(0, 3) == 0) begin
         len = int'(max_len) - 6 + $urandom_range(0, 2);
      end else begin
         len = $urandom_range(0, 20);
      end
      return len;
   endfunction

   // dollar, body, star, two hex digits, optional cr, line feed; a flaw alters or drops parts
   task automatic send_sentence(input sentence_flaw_type flaw, input bit with_cr);
      logic [ByteWidth-1:0] sum;
      logic [ByteWidth-1:0] hi;
      logic [ByteWidth-1:0] lo;
      logic [ByteWidth-1:0] bad;
      logic [4:0]           bad_value;
      sum = '0;
      send_byte(CHAR_DOLLAR);
      foreach (sentence_body[i]) begin
         sum = sum ^ sentence_body[i];
         send_byte(sentence_body[i]);
      end
      if (flaw == FLAW_SUM) begin
         sum = sum ^ 8'($urandom_range(1, 255));
      end
      hi = hex_char(sum[7:4]);
      lo = hex_char(sum[3:0]);
      if (flaw == FLAW_DIGIT) begin
         // anything but a hex digit or a line feed, in either position
         do begin
            bad       = 8'($urandom);
            bad_value = digit_value(bad);
         end while (!bad_value[4] || bad == CHAR_LF);
         if ($urandom_range(0, 1) == 0) begin
            hi = bad;
         end else begin
            lo = bad;
         end
      end
      if (flaw != FLAW_NO_STAR) begin
         send_byte(CHAR_STAR);
         if (flaw != FLAW_NO_DIGITS) begin
            send_byte(hi);
            if (flaw != FLAW_ONE_DIGIT) begin
               send_byte(lo);
            end
         end
      end
      if (with_cr) begin
         send_byte(CHAR_CR);
      end
      send_byte(CHAR_LF);
   endtask

   // A0 A1, length, then length plus three bytes of any value
   task automatic send_binary(input logic [ByteWidth-1:0] hi, input logic [ByteWidth-1:0] lo);
      int unsigned count;
      count = {hi, lo} + 3;
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(hi);
      send_byte(lo);
      repeat (count) send_byte(8'($urandom));
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   task automatic test_ascii_checksum();
      // empty body gives a sum of 00, a lone FF byte gives FF
      fill_body(0);
      send_sentence(FLAW_NONE, 1'b0);
      sentence_body = '{8'hFF};
      send_sentence(FLAW_NONE, 1'b1);
      // dollar and binary sync bytes inside a sentence are plain content
      sentence_body = '{8'h00, CHAR_DOLLAR, SYNC_FIRST, SYNC_SECOND};
      send_sentence(FLAW_NONE, 1'b0);
      fill_body(2);
      send_sentence(FLAW_SUM, 1'b0);
      fill_body(1);
      send_sentence(FLAW_DIGIT, 1'b0);
      fill_body(1);
      send_sentence(FLAW_NO_STAR, 1'b0);
      fill_body(0);
      send_sentence(FLAW_ONE_DIGIT, 1'b0);
      fill_body(0);
      send_sentence(FLAW_NO_DIGITS, 1'b0);
   endtask

   task automatic test_binary_sync();
      // lone A0 then something else, and A0 A0 A1 still syncing
      send_byte(SYNC_FIRST);
      send_byte(8'h55);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(8'h00);
      send_byte(8'h01);
      // body carrying sync and dollar bytes
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(CHAR_DOLLAR);
      send_byte(8'hFF);
      // A0 followed by a dollar opens a sentence, closed without checksum
      send_byte(SYNC_FIRST);
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_LF);
      // stray A1 and line feed outside any frame
      send_byte(SYNC_SECOND);
      send_byte(CHAR_LF);
   endtask

   task automatic test_sentence_limit();
      // limit of 12: exactly 12 bytes pass, 13 abort on the line feed
      write_max_len(8'd12);
      fill_body(7);
      send_sentence(FLAW_NONE, 1'b0);
      fill_body(7);
      send_sentence(FLAW_NONE, 1'b1);
      // below the usual range: zero aborts on the dollar itself
      write_max_len(8'd0);
      fill_body(2);
      send_sentence(FLAW_NONE, 1'b0);
      write_max_len(8'd1);
      fill_body(2);
      send_sentence(FLAW_NONE, 1'b0);
      write_max_len(8'd5);
      fill_body(0);
      send_sentence(FLAW_NONE, 1'b0);
      fill_body(1);
      send_sentence(FLAW_NONE, 1'b0);
      write_max_len(MaxLenReset);
   endtask

   task automatic test_long_binary();
      // length high byte weighted 256, no idling
      steady = 1'b1;
      send_binary(8'h01, 8'h00);
      steady = 1'b0;
   endtask

   task automatic test_random_traffic();
      int unsigned          target;
      int unsigned          next_cfg;
      int unsigned          pick;
      logic [ByteWidth-1:0] b;
      target   = bytes_sent + 300;
      next_cfg = bytes_sent + 100;
      while (bytes_sent < target) begin
         // occasional stretch with no idling on either side
         steady = ($urandom_range(0, 5) == 0);
         if (bytes_sent >= next_cfg) begin
            case ($urandom_range(0, 4))
               0:       b = 8'd12;
               1:       b = 8'd255;
               2:       b = MaxLenReset;
               3:       b = 8'($urandom_range(0, 11));
               default: b = 8'($urandom_range(12, 255));
            endcase
            write_max_len(b);
            next_cfg = bytes_sent + 100;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            fill_body(sentence_body_len());
            send_sentence(FLAW_NONE, 1'($urandom_range(0, 1)));
         end else if (pick < 62) begin
            fill_body(sentence_body_len());
            send_sentence(sentence_flaw_type'($urandom_range(FLAW_SUM, FLAW_NO_DIGITS)),
                          1'($urandom_range(0, 1)));
         end else if (pick < 80) begin
            send_binary(8'h00, 8'($urandom_range(0, 24)));
         end else if (pick < 88) begin
            // line noise that cannot open a frame
            repeat ($urandom_range(1, 6)) begin
               do b = 8'($urandom); while (b == CHAR_DOLLAR || b == SYNC_FIRST);
               send_byte(b);
            end
         end else if (pick < 94) begin
            // broken sync
            send_byte(SYNC_FIRST);
            do b = 8'($urandom); while (b == SYNC_SECOND);
            send_byte(b);
         end else begin
            // sentence cut short, left to run into the next one or the limit
            send_byte(CHAR_DOLLAR);
            repeat ($urandom_range(0, 30)) send_byte(body_char());
         end
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      steady      = 1'b0;
      error_count = 0;
      cycle_count = 0;
      bytes_sent  = 0;
      phase       = HUNTING;
      max_len     = MaxLenReset;
      run_xor     = '0;
      sum_given   = '0;
      digit_fault = 1'b0;
      sent_len    = '0;
      len_high    = '0;
      bin_left    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_ascii_checksum();
      test_binary_sync();
      test_sentence_limit();
      test_long_binary();
      test_random_traffic();

      wait_idle();
      if (error_count == 0) begin
         $display("PASS gnss_sentence_framer");
      end else begin
         $display("FAIL gnss_sentence_framer");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/gsf_pkg.sv
rtl/gsf_parser.sv
rtl/gnss_sentence_framer.sv
tb/sv/gnss_sentence_framer_tb.sv
